>>> src/dbc_pkg.sv
// Package: shared types and constants for the dirty band coalescer.
package dbc_pkg;

   localparam int LINE_W       = 10;
   localparam int REGION_W     = 12;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 10;
   localparam int DEF_MAX_BANDS = 10;

   localparam logic [LINE_W-1:0] HEIGHT_RESET = LINE_W'(320);

   localparam logic REQ_MARK  = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = CSR_INDEX_W'(1);

   typedef struct packed {
      logic                       req_type;
      logic signed [REGION_W-1:0] region_top;
      logic signed [REGION_W-1:0] region_height;
   } dbc_req_type;

   typedef struct packed {
      logic [LINE_W-1:0] band_top;
      logic [LINE_W-1:0] band_height;
      logic              last_band;
   } dbc_rsp_type;

endpackage

>>> src/dirty_band_coalescer_core.sv
// Top level: dirty band table with mark and flush transactions.
//
// Keeps up to MAX_BANDS dirty line bands of a framebuffer. A mark transaction clamps
// [region_top, region_top + region_height) to [0, canvas_height), then one shared
// compare unit walks the stored bands one per cycle; the first band that overlaps or
// touches is widened, otherwise the band is appended, and a full table collapses to
// one band covering the whole canvas. A mark is accepted in S_IDLE and then
// scanned in S_SCAN, the single compare unit stepping through the table. A flush
// emits one rsp transaction per stored band in table order, one per cycle while
// rsp_stall is low, last_band set on the final one, then empties the table; an
// empty flush emits nothing. The block takes no new req transaction while a scan
// or flush is in progress (req_stall high); the rsp output register lets the final
// band wait on rsp_stall while a new req is taken. While enabled_ff is zero every
// req is taken and dropped. Configuration is written through the csr port; the
// user must write it only while idle, and the block itself does not enforce this;
// writes to unused indexes are dropped. No clearing pass is needed after reset.
module dirty_band_coalescer_core #(
   parameter int MAX_BANDS = dbc_pkg::DEF_MAX_BANDS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dbc_pkg::dbc_req_type            req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dbc_pkg::dbc_rsp_type            rsp_payload,
   input  logic                            csr_write_en,
   input  logic [dbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dbc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dbc_pkg::*;

   localparam int IDX_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int CNT_W = $clog2(MAX_BANDS + 1);
   localparam int SUM_W = REGION_W + 1;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_FLUSH = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic              enabled_ff;
   logic [LINE_W-1:0] height_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [LINE_W-1:0] lo_ff, lo_in;
   logic [LINE_W-1:0] hi_ff, hi_in;
   logic              rsp_valid_ff, rsp_valid_in;
   dbc_rsp_type       rsp_ff, rsp_in;

   // band table, one write port, one registered read port fetching the next scan or flush index
   logic [LINE_W-1:0] start_mem [MAX_BANDS];
   logic [LINE_W-1:0] end_mem   [MAX_BANDS];

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [LINE_W-1:0] wr_start;
   logic [LINE_W-1:0] wr_end;

   logic [IDX_W-1:0]  rd_addr;
   logic [LINE_W-1:0] rd_start_ff;
   logic [LINE_W-1:0] rd_end_ff;

   logic              req_accept;
   logic              out_free;
   logic              hit;
   logic              last_sel;

   // mark clamp, evaluated at accept
   logic signed [SUM_W-1:0] top_ext;
   logic signed [SUM_W-1:0] sum_ext;
   logic signed [SUM_W-1:0] lim_ext;
   logic signed [SUM_W-1:0] lo_ext;
   logic signed [SUM_W-1:0] hi_ext;
   logic                    band_ok;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // read data is registered from idx_in, so it lines up with idx_ff
   assign rd_addr  = idx_in[IDX_W-1:0];

   // touching counts as overlapping
   assign hit      = (lo_ff <= rd_end_ff) && (hi_ff >= rd_start_ff);
   assign last_sel = (idx_ff == count_ff - CNT_W'(1));

   always_comb begin
      top_ext = {req_payload.region_top[REGION_W-1], req_payload.region_top};
      sum_ext = top_ext + {req_payload.region_height[REGION_W-1], req_payload.region_height};
      lim_ext = {{(SUM_W-LINE_W){1'b0}}, height_ff};
      lo_ext  = top_ext[SUM_W-1] ? '0 : top_ext;
      hi_ext  = (sum_ext > lim_ext) ? lim_ext : sum_ext;
      band_ok = hi_ext > lo_ext;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_start     = lo_ff;
      wr_end       = hi_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && enabled_ff) begin
               idx_in = '0;
               if (req_payload.req_type == REQ_FLUSH) begin
                  if (count_ff != '0) begin
                     state_in = S_FLUSH;
                  end
               end else if (band_ok) begin
                  lo_in    = lo_ext[LINE_W-1:0];
                  hi_in    = hi_ext[LINE_W-1:0];
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (idx_ff == count_ff) begin
               wr_en = 1'b1;
               if (count_ff < CNT_W'(MAX_BANDS)) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  // table full: collapse to the whole canvas
                  wr_addr  = '0;
                  wr_start = '0;
                  wr_end   = height_ff;
                  count_in = CNT_W'(1);
               end
               state_in = S_IDLE;
            end else if (hit) begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff[IDX_W-1:0];
               wr_start = (lo_ff < rd_start_ff) ? lo_ff : rd_start_ff;
               wr_end   = (hi_ff > rd_end_ff) ? hi_ff : rd_end_ff;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.band_top    = rd_start_ff;
               rsp_in.band_height = rd_end_ff - rd_start_ff;
               rsp_in.last_band   = last_sel;
               if (last_sel) begin
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         enabled_ff   <= 1'b0;
         height_ff    <= HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_ENABLE: enabled_ff <= csr_wdata[0];
               CSR_HEIGHT: height_ff  <= csr_wdata[LINE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_ff      <= rsp_in;
      rd_start_ff <= start_mem[rd_addr];
      rd_end_ff   <= end_mem[rd_addr];
      if (wr_en) begin
         start_mem[wr_addr] <= wr_start;
         end_mem[wr_addr]   <= wr_end;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BANDS))
      else $error("band count above table size");

   a_flush_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |-> (idx_ff < count_ff))
      else $error("flush index past stored bands");

   a_scan_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff <= count_ff))
      else $error("scan index past table fill");

   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && out_free && last_sel)
      |=> (count_ff == '0 && state_ff == S_IDLE && rsp_valid_ff && rsp_ff.last_band))
      else $error("flush did not finish on last band");

endmodule

>>> tb/dirty_band_coalescer_core_tb.sv
// Testbench: directed script and randomized mark/flush traffic for the dirty band coalescer.
module dirty_band_coalescer_core_tb;
   import dbc_pkg::*;

   // Cycles to let a mark scan finish after the last flushed band (a mark has no rsp).
   localparam int SCAN_SETTLE = DEF_MAX_BANDS + 6;
   localparam int LIMIT_TIME  = 1000000;

   // Indexes past the register list; writes there must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = CSR_INDEX_W'(3);

   // Script rows: a req transaction checked by the tracker, a flush whose single band is
   // typed in, or a register write.
   typedef enum logic [1:0] {STEP_REQ, STEP_TYPED, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type          kind;
      dbc_req_type            req;
      dbc_rsp_type            band;     // typed band for STEP_TYPED
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      logic [3:0]             copies;   // repeat count, region_top advances by stride
      logic [5:0]             stride;
   } step_type;

   localparam dbc_rsp_type NO_BAND  = '0;
   localparam logic [11:0] MOST_NEG = 12'h800;

   localparam int SCRIPT_LEN = 32;
   localparam step_type SCRIPT [SCRIPT_LEN] = '{
      // canvas still disabled after reset: both dropped
      '{STEP_REQ,   '{REQ_MARK,  12'sd0, 12'sd10},     NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_REQ,   '{REQ_FLUSH, 12'sd0, 12'sd0},      NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_CSR,   '0,                                NO_BAND, CSR_ENABLE, 10'd1, 4'd1, 6'd0},
      // flush of an empty table
      '{STEP_REQ,   '{REQ_FLUSH, 12'sd0, 12'sd0},      NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_REQ,   '{REQ_MARK,  12'sd0, 12'sd10},     NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_TYPED, '{REQ_FLUSH, 12'sd0, 12'sd0},
                    '{10'd0, 10'd10, 1'b1},                     CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      // negative top clamps to line 0
      '{STEP_REQ,   '{REQ_MARK,  -12'sd5, 12'sd20},    NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_TYPED, '{REQ_FLUSH, 12'sd0, 12'sd0},
                    '{10'd0, 10'd15, 1'b1},                     CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      // top past the canvas bottom: empty after clamping
      '{STEP_REQ,   '{REQ_MARK,  12'sd2047, 12'sd2047}, NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_REQ,   '{REQ_MARK,  12'sd300, 12'sd2047},  NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      // new end touches a stored start
      '{STEP_REQ,   '{REQ_MARK,  12'sd280, 12'sd20},    NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      // most negative height marks nothing
      '{STEP_REQ,   '{REQ_MARK,  12'sd10, MOST_NEG},    NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_REQ,   '{REQ_MARK,  12'sd100, 12'sd10},    NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      // new start touches a stored end
      '{STEP_REQ,   '{REQ_MARK,  12'sd110, 12'sd5},     NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_REQ,   '{REQ_FLUSH, 12'sd0, 12'sd0},       NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_CSR,   '0,                                 NO_BAND, CSR_HEIGHT, 10'd1023, 4'd1, 6'd0},
      '{STEP_REQ,   '{REQ_MARK,  12'sd1000, 12'sd2047}, NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      // ten disjoint single lines: nine fill the table, the tenth collapses it
      '{STEP_REQ,   '{REQ_MARK,  12'sd0, 12'sd1},       NO_BAND, CSR_ENABLE, 10'd0, 4'd10, 6'd3},
      '{STEP_TYPED, '{REQ_FLUSH, 12'sd0, 12'sd0},
                    '{10'd0, 10'd1023, 1'b1},                   CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_REQ,   '{REQ_MARK,  12'sd500, 12'sd100},   NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      // shrinking the canvas keeps the stored band
      '{STEP_CSR,   '0,                                 NO_BAND, CSR_HEIGHT, 10'd320, 4'd1, 6'd0},
      '{STEP_CSR,   '0,                                 NO_BAND, CSR_SPARE_A, 10'd1023, 4'd1, 6'd0},
      '{STEP_CSR,   '0,                                 NO_BAND, CSR_SPARE_B, 10'd0, 4'd1, 6'd0},
      // disabled flush keeps the table
      '{STEP_CSR,   '0,                                 NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_REQ,   '{REQ_FLUSH, 12'sd0, 12'sd0},       NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_CSR,   '0,                                 NO_BAND, CSR_ENABLE, 10'd1, 4'd1, 6'd0},
      '{STEP_TYPED, '{REQ_FLUSH, 12'sd0, 12'sd0},
                    '{10'd500, 10'd100, 1'b1},                  CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      // zero-line canvas: every mark is empty
      '{STEP_CSR,   '0,                                 NO_BAND, CSR_HEIGHT, 10'd0, 4'd1, 6'd0},
      '{STEP_REQ,   '{REQ_MARK,  12'sd0, 12'sd2047},    NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_CSR,   '0,                                 NO_BAND, CSR_HEIGHT, 10'd1, 4'd1, 6'd0},
      '{STEP_REQ,   '{REQ_MARK,  12'sd0, 12'sd2047},    NO_BAND, CSR_ENABLE, 10'd0, 4'd1, 6'd0},
      '{STEP_TYPED, '{REQ_FLUSH, 12'sd0, 12'sd0},
                    '{10'd0, 10'd1, 1'b1},                      CSR_ENABLE, 10'd0, 4'd1, 6'd0}
   };

   // Random phases: register settings, traffic mix and idling per phase.
   // PICK_HEIGHT draws a random canvas height; gap odds 0 means no idle bursts and no rsp stalls.
   localparam int PICK_HEIGHT = -1;
   localparam int PHASES = 7;
   localparam int PHASE_ITEMS  [PHASES] = '{60, 80, 10, 30, 80, 50, 40};
   localparam int PHASE_ON     [PHASES] = '{1, 1, 0, 1, 1, 1, 1};
   localparam int PHASE_HEIGHT [PHASES] = '{320, 1023, 1023, 1, 700, PICK_HEIGHT, 1023};
   localparam int PHASE_FLUSH  [PHASES] = '{10, 4, 10, 12, 6, 10, 8};
   localparam int PHASE_GAPS   [PHASES] = '{4, 3, 4, 0, 5, 3, 0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   dbc_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   dbc_rsp_type rsp_payload;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   dirty_band_coalescer_core #(.MAX_BANDS(DEF_MAX_BANDS)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Shadow of the band table and registers.
   logic              canvas_on;
   int                canvas_lines;
   logic [LINE_W-1:0] band_lo [DEF_MAX_BANDS];
   logic [LINE_W-1:0] band_hi [DEF_MAX_BANDS];
   logic [3:0]        bands_held;

   dbc_rsp_type due_bands [$];   // bands still owed by the block, oldest first
   int          mismatches = 0;
   int          gap_odds = 3;    // 1-in-N chance of an idle burst; 0 disables

   initial begin
      forever #1 clock = ~clock;
   end

   // Apply one accepted req transaction to the shadow table; flushed bands are queued
   // when keep is set (typed script rows queue their own).
   function automatic void track_request(input dbc_req_type r, input bit keep);
      int          lo, hi, i;
      bit          merged;
      dbc_rsp_type b;
      if (!canvas_on) return;
      if (r.req_type == REQ_MARK) begin
         lo = ($signed(r.region_top) < 0) ? 0 : int'($signed(r.region_top));
         hi = int'($signed(r.region_top)) + int'($signed(r.region_height));
         if (hi > canvas_lines) hi = canvas_lines;
         if (hi <= lo) return;
         merged = 1'b0;
         for (i = 0; i < int'(bands_held) && !merged; i++) begin
            // touching counts as overlap
            if (lo <= int'(band_hi[i]) && hi >= int'(band_lo[i])) begin
               if (lo < int'(band_lo[i])) band_lo[i] = LINE_W'(lo);
               if (hi > int'(band_hi[i])) band_hi[i] = LINE_W'(hi);
               merged = 1'b1;
            end
         end
         if (merged) return;
         if (int'(bands_held) < DEF_MAX_BANDS) begin
            band_lo[bands_held] = LINE_W'(lo);
            band_hi[bands_held] = LINE_W'(hi);
            bands_held++;
         end else begin
            // full table: one band over the whole canvas
            band_lo[0] = '0;
            band_hi[0] = LINE_W'(canvas_lines);
            bands_held = 4'd1;
         end
      end else begin
         for (i = 0; i < int'(bands_held); i++) begin
            b.band_top    = band_lo[i];
            b.band_height = band_hi[i] - band_lo[i];
            b.last_band   = (i + 1 == int'(bands_held));
            if (keep) due_bands.push_back(b);
         end
         bands_held = '0;
      end
   endfunction

   task automatic note_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // One req transaction, with an optional idle burst ahead of it. Valid stays high
   // after acceptance until the next call or go_idle drives it.
   task automatic send_req(input dbc_req_type r, input bit typed, input dbc_rsp_type band);
      int gap;
      gap = 0;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) gap = $urandom_range(1, 3);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      track_request(r, !typed);
      if (typed) due_bands.push_back(band);
   endtask

   // Stop sending, collect every owed band, then let a trailing mark scan finish.
   task automatic go_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_bands.size() != 0) @(posedge clock);
      repeat (SCAN_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      if (idx == CSR_ENABLE) canvas_on = val[0];
      else if (idx == CSR_HEIGHT) canvas_lines = int'(val);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // rsp side back-pressure: stall bursts start at random, and none start while gap_odds is zero
   initial begin : rsp_backpressure
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted rsp transaction is matched against the oldest owed band.
   always @(posedge clock) begin : band_check
      dbc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_bands.size() == 0) begin
            note_mismatch("unexpected band, band_top", int'(rsp_payload.band_top), -1);
         end else begin
            want = due_bands.pop_front();
            if (rsp_payload.band_top !== want.band_top)
               note_mismatch("band_top", int'(rsp_payload.band_top), int'(want.band_top));
            if (rsp_payload.band_height !== want.band_height)
               note_mismatch("band_height", int'(rsp_payload.band_height),
                             int'(want.band_height));
            if (rsp_payload.last_band !== want.last_band)
               note_mismatch("last_band", int'(rsp_payload.last_band), int'(want.last_band));
         end
      end
   end

   initial begin : stimulus
      step_type    row;
      dbc_req_type r;
      int          s, k, p, n, top, len, roll, h;

      canvas_on    = 1'b0;
      canvas_lines = int'(HEIGHT_RESET);
      bands_held   = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed script
      for (s = 0; s < SCRIPT_LEN; s++) begin
         row = SCRIPT[s];
         if (row.kind == STEP_CSR) begin
            go_idle();
            write_csr(row.csr_idx, row.csr_val);
         end else begin
            for (k = 0; k < int'(row.copies); k++) begin
               r = row.req;
               r.region_top = row.req.region_top + REGION_W'(k * int'(row.stride));
               send_req(r, row.kind == STEP_TYPED, row.band);
            end
         end
      end

      // Random phases
      for (p = 0; p < PHASES; p++) begin
         go_idle();
         gap_odds = PHASE_GAPS[p];
         h = (PHASE_HEIGHT[p] == PICK_HEIGHT) ? int'($urandom_range(2, 1022))
                                              : PHASE_HEIGHT[p];
         write_csr(CSR_ENABLE, CSR_DATA_W'(PHASE_ON[p]));
         write_csr(CSR_HEIGHT, CSR_DATA_W'(h));
         for (n = 0; n < PHASE_ITEMS[p]; n++) begin
            // occasional full drain before the next transaction
            if ($urandom_range(0, 59) == 0) go_idle();
            roll = $urandom_range(0, 99);
            if (roll < PHASE_FLUSH[p]) begin
               r.req_type      = REQ_FLUSH;
               r.region_top    = REGION_W'($urandom);
               r.region_height = REGION_W'($urandom);
            end else if (roll < PHASE_FLUSH[p] + 15) begin
               // noise: any field value, mostly marks
               r.req_type      = ($urandom_range(0, 7) == 0) ? REQ_FLUSH : REQ_MARK;
               r.region_top    = REGION_W'($urandom);
               r.region_height = REGION_W'($urandom);
            end else begin
               // plausible mark near the canvas, small bands so the table fills
               top = int'($urandom_range(0, canvas_lines + 8)) - 4;
               len = int'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 12));
               r.req_type      = REQ_MARK;
               r.region_top    = REGION_W'(top);
               r.region_height = REGION_W'(len);
            end
            send_req(r, 1'b0, NO_BAND);
         end
      end

      go_idle();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_TIME);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
